// File: hw/rtl/imufp_pkg.sv
// ============================================================================
// imufp_pkg
// Shared widths, frame codes and parse phases for the IMU frame parser.
// ============================================================================
package imufp_pkg;

    // Data bytes between the type byte and the checksum byte
    localparam int unsigned PAYLOAD_BYTES = 8;
    localparam int unsigned COUNT_W       = $clog2(PAYLOAD_BYTES);

    // Field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned TYPE_W = 7;
    localparam int unsigned WORD_W = 16;

    // Frame type range and sync default
    localparam logic [BYTE_W-1:0] TYPE_LOW   = 8'h50;
    localparam logic [BYTE_W-1:0] TYPE_HIGH  = 8'h5A;
    localparam logic [BYTE_W-1:0] TYPE_ANGLE = 8'h53;
    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h55;

    // Parse phases
    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_TYPE  = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_CHECK = 2'd3;

    // Register bus
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic        REG_SYNC = 1'b0;   // word index of sync_byte

endpackage

// File: hw/rtl/imufp_if.sv
// ============================================================================
// imufp_if
// Valid/ready channels: received bytes in, decoded frames out.
// ============================================================================
interface imufp_byte_if;
    logic                          valid;
    logic                          ready;
    logic [imufp_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imufp_frame_if;
    logic                                valid;
    logic                                ready;
    logic        [imufp_pkg::TYPE_W-1:0] frame_type;
    logic signed [imufp_pkg::WORD_W-1:0] word_x;
    logic signed [imufp_pkg::WORD_W-1:0] word_y;
    logic signed [imufp_pkg::WORD_W-1:0] word_z;
    logic        [imufp_pkg::WORD_W-1:0] word_extra;

    modport source (output valid, output frame_type, output word_x, output word_y,
                    output word_z, output word_extra, input ready);
    modport sink   (input valid, input frame_type, input word_x, input word_y,
                    input word_z, input word_extra, output ready);
endinterface

// File: hw/rtl/imufp_apb_regs.sv
// ============================================================================
// imufp_apb_regs
// APB register slave holding the sync byte.
// ============================================================================
module imufp_apb_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [imufp_pkg::PADDR_W-1:0]     paddr,
    input  logic [imufp_pkg::PDATA_W-1:0]     pwdata,
    output logic [imufp_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready,
    output logic [imufp_pkg::BYTE_W-1:0]      o_sync_byte
);

    logic [imufp_pkg::BYTE_W-1:0] r_sync;
    logic                         w_sel_sync;
    logic                         w_wr;

    // Byte-lane bits of the address are ignored
    assign w_sel_sync = (paddr[imufp_pkg::PADDR_W-1] == imufp_pkg::REG_SYNC);
    assign w_wr       = psel && penable && pwrite;
    assign pready     = 1'b1;

    // Sync byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= imufp_pkg::SYNC_RESET;
        end else if (w_wr && w_sel_sync) begin
            r_sync <= pwdata[imufp_pkg::BYTE_W-1:0];
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        if (w_sel_sync) begin
            prdata[imufp_pkg::BYTE_W-1:0] = r_sync;
        end
    end

    assign o_sync_byte = r_sync;

endmodule

// File: hw/rtl/imu_frame_parser_sum_check.sv
// ============================================================================
// imu_frame_parser_sum_check
// Serial sensor frame parser with an 8-bit modular sum check.
// ============================================================================
// Usage:
//   i_rx carries one received serial byte per beat. The parser hunts for the
//   sync byte (APB register at address 0, reset 0x55), then expects a type
//   byte 0x50..0x5A, eight data bytes and a checksum byte equal to the 8-bit
//   sum of sync, type and data. A bad type drops back to hunting without
//   re-testing that byte as sync; a bad checksum drops the frame silently.
//   o_frame carries one beat per good frame: its type and four little-endian
//   16-bit words (x, y, z signed; extra raw).
// Timing:
//   One byte per cycle unless a stalled beat holds the checksum byte.
//   The frame beat is valid the cycle after the checksum byte is taken; the
//   phase, running sum and byte counter update in the same cycle as each byte.
// Reset and stall:
//   Reset (synchronous, active low) returns to hunting and empties the output
//   register. While a frame beat waits on o_frame, bytes are still taken in
//   every phase except the checksum phase, which waits for the output slot.
// ============================================================================
module imu_frame_parser_sum_check (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    imufp_byte_if.sink                        i_rx,
    imufp_frame_if.source                     o_frame,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [imufp_pkg::PADDR_W-1:0]     paddr,
    input  logic [imufp_pkg::PDATA_W-1:0]     pwdata,
    output logic [imufp_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);

    logic [imufp_pkg::BYTE_W-1:0]  w_sync;

    logic [1:0]                    r_phase, n_phase;
    logic [imufp_pkg::TYPE_W-1:0]  r_kind,  n_kind;
    logic [imufp_pkg::COUNT_W-1:0] r_count, n_count;
    logic [imufp_pkg::BYTE_W-1:0]  r_sum,   n_sum;
    logic [imufp_pkg::BYTE_W-1:0]  r_payload [imufp_pkg::PAYLOAD_BYTES];

    logic                          r_out_valid;
    logic [imufp_pkg::TYPE_W-1:0]  r_out_type;
    logic [imufp_pkg::WORD_W-1:0]  r_out_x, r_out_y, r_out_z, r_out_extra;

    logic                          w_fire;
    logic                          w_type_ok;
    logic                          w_load;
    logic [imufp_pkg::BYTE_W-1:0]  w_byte;

    // Register slave
    imufp_apb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_sync_byte (w_sync)
    );

    // Input handshake: only the checksum beat needs a free output slot
    assign i_rx.ready = !r_out_valid || o_frame.ready || (r_phase != imufp_pkg::PH_CHECK);
    assign w_fire     = i_rx.valid && i_rx.ready;
    assign w_byte     = i_rx.rx_byte;
    assign w_type_ok  = w_byte inside {[imufp_pkg::TYPE_LOW:imufp_pkg::TYPE_HIGH]};
    assign w_load     = w_fire && (r_phase == imufp_pkg::PH_CHECK) && (w_byte == r_sum);

    // Parse phase, running sum, counter
    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_count = r_count;
        n_sum   = r_sum;
        if (w_fire) begin
            case (r_phase)
                imufp_pkg::PH_HUNT: begin
                    if (w_byte == w_sync) begin
                        n_sum   = w_byte;
                        n_phase = imufp_pkg::PH_TYPE;
                    end
                end
                imufp_pkg::PH_TYPE: begin
                    if (w_type_ok) begin
                        n_kind  = w_byte[imufp_pkg::TYPE_W-1:0];
                        n_sum   = r_sum + w_byte;
                        n_count = '0;
                        n_phase = imufp_pkg::PH_DATA;
                    end else begin
                        n_phase = imufp_pkg::PH_HUNT;
                    end
                end
                imufp_pkg::PH_DATA: begin
                    n_sum   = r_sum + w_byte;
                    n_count = r_count + 1'b1;
                    if (r_count == imufp_pkg::COUNT_W'(imufp_pkg::PAYLOAD_BYTES - 1)) begin
                        n_phase = imufp_pkg::PH_CHECK;
                    end
                end
                default: begin
                    n_count = '0;
                    n_phase = imufp_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= imufp_pkg::PH_HUNT;
            r_kind  <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    // Payload capture
    always_ff @(posedge i_clk) begin
        if (w_fire && (r_phase == imufp_pkg::PH_DATA)) begin
            r_payload[r_count] <= w_byte;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_type  <= r_kind;
            r_out_x     <= {r_payload[1], r_payload[0]};
            r_out_y     <= {r_payload[3], r_payload[2]};
            r_out_z     <= {r_payload[5], r_payload[4]};
            r_out_extra <= {r_payload[7], r_payload[6]};
        end
    end

    assign o_frame.valid      = r_out_valid;
    assign o_frame.frame_type = r_out_type;
    assign o_frame.word_x     = $signed(r_out_x);
    assign o_frame.word_y     = $signed(r_out_y);
    assign o_frame.word_z     = $signed(r_out_z);
    assign o_frame.word_extra = r_out_extra;

    // Checks
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_out_valid || o_frame.ready))
        else $error("frame beat overwritten while stalled");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == imufp_pkg::PH_DATA || r_phase == imufp_pkg::PH_CHECK) |->
        ({1'b0, r_kind} >= imufp_pkg::TYPE_LOW && {1'b0, r_kind} <= imufp_pkg::TYPE_HIGH))
        else $error("frame kind out of range during frame");

    a_sync_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_phase == imufp_pkg::PH_HUNT && w_byte == w_sync) |=>
        (r_phase == imufp_pkg::PH_TYPE && r_sum == $past(w_byte)))
        else $error("sync byte not taken");

    a_check_after_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == imufp_pkg::PH_CHECK) |-> (r_count == '0))
        else $error("checksum phase reached with partial payload");

    a_load_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_out_valid && r_phase == imufp_pkg::PH_HUNT))
        else $error("frame beat not presented after good checksum");

endmodule
